[rtl/core/wildcard_packet_blocklist_filter_assert.svh]
`ifndef WILDCARD_PACKET_BLOCKLIST_FILTER_ASSERT_SVH
`define WILDCARD_PACKET_BLOCKLIST_FILTER_ASSERT_SVH

// same-cycle implication
`define WPBF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wpbf assertion failed");

// next-cycle implication
`define WPBF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wpbf assertion failed");

`endif

[rtl/core/wpbf_pkg.sv]
`timescale 1ns / 1ps

package wpbf_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 256;
    localparam int KEY_W = 56;
    localparam int ENTRY_W = KEY_W + 1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [1:0] REQ_CLASSIFY = 2'd0;
    localparam logic [1:0] REQ_INSERT   = 2'd1;
    localparam logic [1:0] REQ_REMOVE   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    function automatic logic [KEY_W-1:0] make_key(input logic [31:0] ip,
                                                  input logic [15:0] port,
                                                  input logic [7:0] proto);
        return {ip, port, proto};
    endfunction

endpackage

[rtl/core/wpbf_table.sv]
`timescale 1ns / 1ps

module wpbf_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int W     = 57
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem_reg [DEPTH];
    logic [W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/wildcard_packet_blocklist_filter.sv]
`timescale 1ns / 1ps

// Destination blocklist filter. Requests arrive on the s_ channel (valid/ready):
// classify a parsed packet, insert a blocklist key or remove one. Each request
// yields exactly one result transaction on the m_ channel: verdict (1 = drop),
// status (ok, table full, key not found) and the 64-bit drop count after it.
// The key table sits in one single-port-read synchronous memory of
// TABLE_ENTRIES words, each a valid bit plus the 56-bit key. Every request
// reads the whole table once, one word per cycle, and checks each word
// against up to five wildcard keys; inserts and removes write back at most one
// word at the end. The scan (ST_SCAN) is followed by ST_DRAIN for the last
// compare and ST_FINISH, which registers the result; a new request is taken
// only after that, back in ST_IDLE, so requests never overlap.
// The result waits in an output register; if the receiver stalls, the block
// finishes the scan and holds in its final step until the register frees.
// After aresetn is released a clearing pass writes every table word invalid,
// with s_ready low for the whole pass; the drop count restarts at zero.
module wildcard_packet_blocklist_filter
    import wpbf_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic        s_parse_ok,
    input  logic [15:0] s_ether_type,
    input  logic [7:0]  s_ip_protocol,
    input  logic [31:0] s_dest_ip,
    input  logic [15:0] s_dest_port,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_verdict,
    output logic [1:0]  m_status,
    output logic [63:0] m_drop_total
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   scan_addr_reg;
    logic            cmp_vld_reg;
    logic [AW-1:0]   cmp_idx_reg;
    logic [1:0]      req_reg;
    logic            check_reg;
    logic [KEY_W-1:0] key0_reg, key1_reg, key2_reg, key3_reg, key4_reg;
    logic            hit_reg;
    logic [AW-1:0]   match_idx_reg;
    logic            free_found_reg;
    logic [AW-1:0]   free_idx_reg;
    logic [63:0]     drop_counter_reg;
    logic            m_valid_reg;
    logic            m_verdict_reg;
    logic [1:0]      m_status_reg;

    logic [15:0]      port_eff;
    logic [15:0]      port_key0;
    logic             is_port_proto;
    logic [ENTRY_W-1:0] rd_data;
    logic             entry_v;
    logic [KEY_W-1:0] entry_k;
    logic             exact_hit;
    logic             any_hit;
    logic             out_free;
    logic             commit;
    logic             do_insert;
    logic             do_remove;
    logic             drop;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic             rd_en;

    always_comb begin
        is_port_proto = s_ip_protocol inside {PROTO_TCP, PROTO_UDP};
        port_eff  = is_port_proto ? s_dest_port : 16'd0;
        port_key0 = (s_req_type == REQ_CLASSIFY) ? port_eff : s_dest_port;
    end

    assign entry_v   = rd_data[KEY_W];
    assign entry_k   = rd_data[KEY_W-1:0];
    assign exact_hit = entry_v && (entry_k == key0_reg);
    assign any_hit   = entry_v && ((entry_k == key0_reg) || (entry_k == key1_reg) ||
                                   (entry_k == key2_reg) || (entry_k == key3_reg) ||
                                   (entry_k == key4_reg));

    assign out_free  = !m_valid_reg || m_ready;
    assign commit    = (state_reg == ST_FINISH) && out_free;
    assign do_insert = (req_reg == REQ_INSERT) && !hit_reg && free_found_reg;
    assign do_remove = (req_reg == REQ_REMOVE) && hit_reg;
    assign drop      = (req_reg == REQ_CLASSIFY) && check_reg && hit_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = scan_addr_reg;
        wr_data = '0;
        case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
            end
            ST_FINISH: begin
                if (commit && do_insert) begin
                    wr_en   = 1'b1;
                    wr_addr = free_idx_reg;
                    wr_data = {1'b1, key0_reg};
                end else if (commit && do_remove) begin
                    wr_en   = 1'b1;
                    wr_addr = match_idx_reg;
                    wr_data = {1'b0, key0_reg};
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign rd_en = (state_reg == ST_SCAN);

    wpbf_table #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW),
        .W     (ENTRY_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            scan_addr_reg    <= '0;
            cmp_vld_reg      <= 1'b0;
            drop_counter_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            cmp_vld_reg <= (state_reg == ST_SCAN);
            cmp_idx_reg <= scan_addr_reg;

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // compare stage for the word read last cycle
            if (cmp_vld_reg) begin
                if ((req_reg == REQ_CLASSIFY) ? any_hit : exact_hit) begin
                    hit_reg <= 1'b1;
                end
                if (exact_hit && !hit_reg) begin
                    match_idx_reg <= cmp_idx_reg;
                end
                if (!entry_v && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end

            case (state_reg)
                ST_CLEAR: begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                    if (scan_addr_reg == LAST_ADDR) begin
                        scan_addr_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg        <= s_req_type;
                        check_reg      <= s_parse_ok && (s_ether_type == ETHERTYPE_IPV4);
                        key0_reg       <= make_key(s_dest_ip, port_key0, s_ip_protocol);
                        key1_reg       <= make_key(s_dest_ip, port_eff, 8'd0);
                        key2_reg       <= make_key(s_dest_ip, 16'd0, 8'd0);
                        key3_reg       <= make_key(32'd0, port_eff, 8'd0);
                        key4_reg       <= make_key(32'd0, port_eff, s_ip_protocol);
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        scan_addr_reg  <= '0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                    if (scan_addr_reg == LAST_ADDR) begin
                        scan_addr_reg <= '0;
                        state_reg     <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_verdict_reg <= drop;
                        m_status_reg  <= STATUS_OK;
                        if ((req_reg == REQ_INSERT) && !hit_reg && !free_found_reg) begin
                            m_status_reg <= STATUS_FULL;
                        end
                        if ((req_reg == REQ_REMOVE) && !hit_reg) begin
                            m_status_reg <= STATUS_NOT_FOUND;
                        end
                        if (drop) begin
                            drop_counter_reg <= drop_counter_reg + 64'd1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_verdict    = m_verdict_reg;
    assign m_status     = m_status_reg;
    assign m_drop_total = drop_counter_reg;

endmodule

[rtl/core/wpbf_checker.sv]
`timescale 1ns / 1ps
`include "wildcard_packet_blocklist_filter_assert.svh"

module wpbf_checker
    import wpbf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_verdict,
    input logic [1:0]  m_status,
    input logic [63:0] m_drop_total
);

    // a dropped packet never carries a table status
    `WPBF_ASSERT_IMP(a_drop_status_ok, aclk, aresetn, m_valid && m_verdict, m_status == STATUS_OK)

    // only defined status codes leave the block
    `WPBF_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, (m_status == STATUS_OK) || (m_status == STATUS_FULL) || (m_status == STATUS_NOT_FOUND))

    // one request in flight: accepting a transaction closes the input
    `WPBF_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // stalled result holds
    `WPBF_ASSERT_NXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_drop_total) && $stable(m_status) && $stable(m_verdict))

endmodule

bind wildcard_packet_blocklist_filter wpbf_checker u_wpbf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_verdict    (m_verdict),
    .m_status     (m_status),
    .m_drop_total (m_drop_total)
);
